[hw/rtl/gb3_pkg.sv]
`timescale 1ns / 1ps

package gb3_pkg;

  // One pixel as it sits in the row store: blue in the low byte.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // Upper and middle row entries that share one row-store address.
  typedef struct packed {
    pix_t upper;
    pix_t middle;
  } row_pair_t;

  // Input item of the pixel stream.
  typedef struct packed {
    logic       op;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } in_item_t;

  // Result item of the pixel stream.
  typedef struct packed {
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       frame_end;
  } out_item_t;

  // Item opcodes.
  localparam logic OP_DRAIN = 1'b1;

  // Register indexes, taken from paddr[2].
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Register widths, reset values and limits.
  localparam int          WIDTH_REG_W  = 12;
  localparam int          HEIGHT_REG_W = 13;
  localparam logic [11:0] WIDTH_RESET  = 12'd640;
  localparam logic [12:0] HEIGHT_RESET = 13'd480;
  localparam logic [12:0] HEIGHT_MIN   = 13'd3;
  localparam logic [12:0] HEIGHT_MAX   = 13'd4096;

endpackage

[hw/rtl/gaussian_blur_3x3_stream.sv]
// Streaming 3x3 binomial blur over three-channel pixels in raster order.
// Throughput: one item per cycle unless out_stall holds the pipeline; the row store is
// read and written once per taken item. Items pass stage 1, the window and the output
// register; a pixel's result leaves with the input item one row plus one pixel later.
// Reset (synchronous, rst_n low) clears counters, window and pipeline valids and sets
// the size registers to 640 x 480; the row store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module gaussian_blur_3x3_stream #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic               clk,
  input  logic               rst_n,
  // Pixel input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  gb3_pkg::in_item_t  in_data,
  // Result channel
  output logic               out_valid,
  input  logic               out_stall,
  output gb3_pkg::out_item_t out_data,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int WCW = (CW > gb3_pkg::WIDTH_REG_W) ? CW : gb3_pkg::WIDTH_REG_W;
  localparam int RW  = gb3_pkg::HEIGHT_REG_W;

  // Configuration registers
  logic [gb3_pkg::WIDTH_REG_W-1:0]  width_r;
  logic [gb3_pkg::HEIGHT_REG_W-1:0] height_r;

  // Position counters
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;
  logic [RW-1:0] out_row_r, out_row_nxt;

  // Stage 1: accepted item waiting for its row-store read
  logic                 s1_v_r, s1_v_nxt;
  gb3_pkg::pix_t        s1_px_r;
  logic [AW-1:0]        s1_addr_r;
  logic                 s1_emit_r;
  logic                 s1_border_r;
  logic                 s1_fe_r;

  // Stage 2: window holds the neighborhood of a pending result
  gb3_pkg::pix_t [8:0]  win_r, win_nxt;
  logic                 s2_v_r, s2_v_nxt;
  logic                 s2_border_r;
  logic                 s2_fe_r;

  // Output register
  logic                 out_v_r, out_v_nxt;
  gb3_pkg::out_item_t   out_r;

  // Effective sizes and control
  logic [WCW-1:0]       w_ext;
  logic [CW-1:0]        w_eff;
  logic [CW-1:0]        w_m1;
  logic [RW-1:0]        h_eff;
  logic [RW-1:0]        h_m1;
  logic                 draining;
  logic                 drop;
  logic                 emit_now;
  logic                 border_now;
  logic                 fe_now;
  logic [AW-1:0]        col_addr;
  logic                 acc;
  logic                 take;
  logic                 out_free;
  logic                 s1_adv;
  logic [CW-1:0]        in_col_inc;
  logic [CW-1:0]        out_col_inc;
  gb3_pkg::pix_t        in_px;
  gb3_pkg::row_pair_t   rd_pair;
  gb3_pkg::row_pair_t   wr_pair;
  gb3_pkg::pix_t        blur_px;
  gb3_pkg::pix_t        res_px;

  // Clamp the size registers to the supported range.
  always_comb begin
    w_ext = WCW'(width_r);
    if (w_ext < WCW'(3)) begin
      w_ext = WCW'(3);
    end else if (w_ext > WCW'(MAX_WIDTH)) begin
      w_ext = WCW'(MAX_WIDTH);
    end
    w_eff = w_ext[CW-1:0];
    w_m1  = w_eff - CW'(1);
    h_eff = height_r;
    if (h_eff < gb3_pkg::HEIGHT_MIN) begin
      h_eff = gb3_pkg::HEIGHT_MIN;
    end else if (h_eff > gb3_pkg::HEIGHT_MAX) begin
      h_eff = gb3_pkg::HEIGHT_MAX;
    end
    h_m1 = h_eff - RW'(1);
  end

  // Handshake and pipeline flow.
  assign out_free = !out_v_r || !out_stall;
  assign s1_adv   = s1_v_r && (!s2_v_r || out_free);
  assign in_stall = s1_v_r && !s1_adv;
  assign acc      = in_valid && !in_stall;

  // Classify the item at the front from the counters.
  always_comb begin
    draining   = (in_row_r >= h_eff);
    drop       = (in_data.op == gb3_pkg::OP_DRAIN) && !draining;
    take       = acc && !drop;
    emit_now   = (in_row_r >= RW'(2)) || ((in_row_r == RW'(1)) && (in_col_r != '0));
    border_now = (out_row_r == '0) || (out_row_r >= h_m1) ||
                 (out_col_r == '0) || (out_col_r >= w_m1);
    fe_now     = (out_row_r >= h_m1) && (out_col_r >= w_m1);
    if (in_col_r >= CW'(MAX_WIDTH - 1)) begin
      col_addr = AW'(MAX_WIDTH - 1);
    end else begin
      col_addr = in_col_r[AW-1:0];
    end
    if (draining) begin
      in_px = '0;
    end else begin
      in_px.blue  = in_data.blue_in;
      in_px.green = in_data.green_in;
      in_px.red   = in_data.red_in;
    end
  end

  // Counter update for each item that enters the pipeline.
  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    in_col_inc  = in_col_r + CW'(1);
    out_col_inc = out_col_r + CW'(1);
    if (take) begin
      if (in_col_inc >= w_eff) begin
        in_col_nxt = '0;
        if (in_row_r != '1) begin
          in_row_nxt = in_row_r + RW'(1);
        end
      end else begin
        in_col_nxt = in_col_inc;
      end
      if (emit_now) begin
        if (out_col_inc >= w_eff) begin
          out_col_nxt = '0;
          if (out_row_r != '1) begin
            out_row_nxt = out_row_r + RW'(1);
          end
        end else begin
          out_col_nxt = out_col_inc;
        end
        if (fe_now) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end
      end
    end
  end

  // Row store: one entry per column holding the two previous rows.
  assign wr_pair.upper  = rd_pair.middle;
  assign wr_pair.middle = s1_px_r;

  gb3_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (take),
    .rd_addr (col_addr),
    .rd_data (rd_pair),
    .wr_en   (s1_adv),
    .wr_addr (s1_addr_r),
    .wr_data (wr_pair)
  );

  // Window shift and pipeline valids.
  always_comb begin
    win_nxt  = win_r;
    s1_v_nxt = s1_v_r;
    s2_v_nxt = s2_v_r;
    out_v_nxt = out_v_r;
    if (acc) begin
      s1_v_nxt = !drop;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
    if (s1_adv) begin
      for (int r = 0; r < 3; r++) begin
        win_nxt[r*3]     = win_r[r*3 + 1];
        win_nxt[r*3 + 1] = win_r[r*3 + 2];
      end
      win_nxt[2] = rd_pair.upper;
      win_nxt[5] = rd_pair.middle;
      win_nxt[8] = s1_px_r;
      s2_v_nxt   = s1_emit_r;
    end else if (out_free) begin
      s2_v_nxt = 1'b0;
    end
    if (s2_v_r && out_free) begin
      out_v_nxt = 1'b1;
    end else if (out_free) begin
      out_v_nxt = 1'b0;
    end
  end

  // Control registers, window and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= gb3_pkg::WIDTH_RESET;
      height_r  <= gb3_pkg::HEIGHT_RESET;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      win_r     <= '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        unique case (paddr[2])
          gb3_pkg::REG_IMAGE_WIDTH:  width_r  <= pwdata[gb3_pkg::WIDTH_REG_W-1:0];
          gb3_pkg::REG_IMAGE_HEIGHT: height_r <= pwdata[gb3_pkg::HEIGHT_REG_W-1:0];
          default: ;
        endcase
      end
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      s1_v_r    <= s1_v_nxt;
      s2_v_r    <= s2_v_nxt;
      out_v_r   <= out_v_nxt;
      win_r     <= win_nxt;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (take) begin
      s1_px_r     <= in_px;
      s1_addr_r   <= col_addr;
      s1_emit_r   <= emit_now;
      s1_border_r <= border_now;
      s1_fe_r     <= fe_now;
    end
    if (s1_adv) begin
      s2_border_r <= s1_border_r;
      s2_fe_r     <= s1_fe_r;
    end
    if (s2_v_r && out_free) begin
      out_r.blue_out  <= res_px.blue;
      out_r.green_out <= res_px.green;
      out_r.red_out   <= res_px.red;
      out_r.frame_end <= s2_fe_r;
    end
  end

  // Kernel on the current window; border pixels pass the center through.
  gb3_kernel u_kernel (
    .win  (win_r),
    .blur (blur_px)
  );

  assign res_px = s2_border_r ? win_r[4] : blur_px;

  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // Register readback.
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[2])
      gb3_pkg::REG_IMAGE_WIDTH:  prdata = 32'(width_r);
      gb3_pkg::REG_IMAGE_HEIGHT: prdata = 32'(height_r);
      default:                   prdata = '0;
    endcase
  end

  // A row-store read always lands in a loaded stage 1.
  a_read_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    take |=> s1_v_r)
    else $error("row-store read without a stage-1 item");

  // Items taken during the drain phase carry a zero pixel.
  a_drain_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (take && draining) |=> (s1_px_r == '0))
    else $error("drain item carried pixel data");

  // The frame-end result returns every position counter to zero.
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (take && emit_now && fe_now) |=>
      ((in_col_r == '0) && (in_row_r == '0) && (out_col_r == '0) && (out_row_r == '0)))
    else $error("counters not cleared after frame end");

endmodule

[hw/rtl/gb3_line_buf.sv]
`timescale 1ns / 1ps

module gb3_line_buf #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output gb3_pkg::row_pair_t  rd_data,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  gb3_pkg::row_pair_t  wr_data
);

  gb3_pkg::row_pair_t mem [DEPTH];
  gb3_pkg::row_pair_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; a write to the same address in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/gb3_kernel.sv]
`timescale 1ns / 1ps

module gb3_kernel (
  input  gb3_pkg::pix_t [8:0] win,
  output gb3_pkg::pix_t       blur
);

  // Binomial 1 2 1 / 2 4 2 / 1 2 1 over one channel, plus 8, divided by 16.
  function automatic logic [7:0] blur_chan(
    input logic [7:0] p0, input logic [7:0] p1, input logic [7:0] p2,
    input logic [7:0] p3, input logic [7:0] p4, input logic [7:0] p5,
    input logic [7:0] p6, input logic [7:0] p7, input logic [7:0] p8
  );
    logic [9:0]  corners;
    logic [9:0]  edges;
    logic [11:0] sum;
    corners = 10'(p0) + 10'(p2) + 10'(p6) + 10'(p8);
    edges   = 10'(p1) + 10'(p3) + 10'(p5) + 10'(p7);
    sum     = 12'd8 + 12'(corners) + {1'b0, edges, 1'b0} + {2'b00, p4, 2'b00};
    return sum[11:4];
  endfunction

  always_comb begin
    blur.blue  = blur_chan(win[0].blue, win[1].blue, win[2].blue,
                           win[3].blue, win[4].blue, win[5].blue,
                           win[6].blue, win[7].blue, win[8].blue);
    blur.green = blur_chan(win[0].green, win[1].green, win[2].green,
                           win[3].green, win[4].green, win[5].green,
                           win[6].green, win[7].green, win[8].green);
    blur.red   = blur_chan(win[0].red, win[1].red, win[2].red,
                           win[3].red, win[4].red, win[5].red,
                           win[6].red, win[7].red, win[8].red);
  end

endmodule

[sim/gaussian_blur_3x3_stream_tb.sv]
`timescale 1ns / 1ps

module gaussian_blur_3x3_stream_tb;

  localparam int   MAX_W        = 2048;
  localparam int   QUIET_LIMIT  = 2000;
  localparam int   TAIL_CYCLES  = 6;
  localparam int   PHASE_ITEMS  = 440;
  localparam logic OP_PIXEL     = ~gb3_pkg::OP_DRAIN;
  localparam int   KERN[9]      = '{1, 2, 1, 2, 4, 2, 1, 2, 1};
  // Idle percentages per phase: none, sender only, receiver only, both light.
  localparam int   PH_SEND[4]   = '{0, 79, 0, 6};
  localparam int   PH_STALL[4]  = '{0, 0, 79, 6};

  typedef struct {
    gb3_pkg::in_item_t  item;
    bit                 has_want;
    gb3_pkg::out_item_t want;
  } stim_row_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  gb3_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  gb3_pkg::out_item_t out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Shadow copy of the block: size registers, row stores, window, counters.
  logic [11:0]        width_reg = gb3_pkg::WIDTH_RESET;
  logic [12:0]        height_reg = gb3_pkg::HEIGHT_RESET;
  gb3_pkg::pix_t      upper_row [MAX_W];
  gb3_pkg::pix_t      middle_row [MAX_W];
  gb3_pkg::pix_t      win [9];
  int unsigned        col_in, row_in, col_out, row_out;

  gb3_pkg::out_item_t blurred_fifo [$];
  stim_row_t          dir_rows [16];
  int                 send_idle_pct = 0;
  int                 stall_pct = 0;
  int                 mismatches = 0;
  int                 quiet_cycles = 0;
  int                 items_taken = 0;
  int                 results_seen = 0;
  int                 frames_done = 0;
  int                 useful_items = 0;

  gaussian_blur_3x3_stream dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver back-pressure for the current phase.
  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  task automatic flag(input string what);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH: %s", what);
  endtask

  function automatic string item_str(input gb3_pkg::out_item_t o);
    return $sformatf("b=%02h g=%02h r=%02h end=%0b", o.blue_out, o.green_out, o.red_out,
                     o.frame_end);
  endfunction

  function automatic int unsigned eff_w();
    if (width_reg < 3) return 3;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  function automatic int unsigned eff_h();
    if (height_reg < gb3_pkg::HEIGHT_MIN) return gb3_pkg::HEIGHT_MIN;
    if (height_reg > gb3_pkg::HEIGHT_MAX) return gb3_pkg::HEIGHT_MAX;
    return height_reg;
  endfunction

  // Advances the shadow copy by one item; returns 1 when it releases a result.
  function automatic bit blur_predict(input gb3_pkg::in_item_t it,
                                      output gb3_pkg::out_item_t res);
    int unsigned   w, h, col;
    int            acc_b, acc_g, acc_r;
    bit            draining, emit;
    gb3_pkg::pix_t px, up, mid, ctr;
    w = eff_w();
    h = eff_h();
    res = '0;
    draining = (row_in >= h);
    // A drain tick before the frame's rows are complete does nothing.
    if (it.op == gb3_pkg::OP_DRAIN && !draining) return 1'b0;
    px = draining ? gb3_pkg::pix_t'('0)
                  : gb3_pkg::pix_t'{it.red_in, it.green_in, it.blue_in};
    col = (col_in >= MAX_W) ? MAX_W - 1 : col_in;
    up = upper_row[col];
    mid = middle_row[col];
    upper_row[col] = mid;
    middle_row[col] = px;
    for (int r = 0; r < 3; r++) begin
      win[r * 3] = win[r * 3 + 1];
      win[r * 3 + 1] = win[r * 3 + 2];
    end
    win[2] = up;
    win[5] = mid;
    win[8] = px;
    emit = (row_in >= 2) || (row_in == 1 && col_in >= 1);
    col_in++;
    if (col_in >= w) begin
      col_in = 0;
      if (row_in < 16'hFFFF) row_in++;
    end
    if (!emit) return 1'b0;

    // Border pixels pass through, interior pixels take the rounded kernel sum.
    ctr = win[4];
    if (row_out == 0 || row_out >= h - 1 || col_out == 0 || col_out >= w - 1) begin
      res.blue_out = ctr.blue;
      res.green_out = ctr.green;
      res.red_out = ctr.red;
    end else begin
      acc_b = 8;
      acc_g = 8;
      acc_r = 8;
      for (int i = 0; i < 9; i++) begin
        acc_b += KERN[i] * win[i].blue;
        acc_g += KERN[i] * win[i].green;
        acc_r += KERN[i] * win[i].red;
      end
      res.blue_out = 8'(acc_b >> 4);
      res.green_out = 8'(acc_g >> 4);
      res.red_out = 8'(acc_r >> 4);
    end
    res.frame_end = (row_out >= h - 1) && (col_out >= w - 1);

    col_out++;
    if (col_out >= w) begin
      col_out = 0;
      if (row_out < 16'hFFFF) row_out++;
    end
    if (res.frame_end) begin
      col_in = 0;
      row_in = 0;
      col_out = 0;
      row_out = 0;
    end
    return 1'b1;
  endfunction

  function automatic gb3_pkg::in_item_t px_item(input logic [7:0] r, g, b);
    gb3_pkg::in_item_t it;
    it.op = OP_PIXEL;
    it.blue_in = b;
    it.green_in = g;
    it.red_in = r;
    return it;
  endfunction

  function automatic gb3_pkg::in_item_t drain_item();
    gb3_pkg::in_item_t it;
    it = '0;
    it.op = gb3_pkg::OP_DRAIN;
    return it;
  endfunction

  function automatic gb3_pkg::out_item_t px_result(input logic [7:0] r, g, b,
                                                   input logic fe);
    gb3_pkg::out_item_t o;
    o.blue_out = b;
    o.green_out = g;
    o.red_out = r;
    o.frame_end = fe;
    return o;
  endfunction

  // Channel values lean toward the extremes.
  function automatic logic [7:0] rand_chan();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic gb3_pkg::in_item_t rand_pixel();
    return px_item(rand_chan(), rand_chan(), rand_chan());
  endfunction

  // Predicts the item, queues any result, then offers it until accepted.
  task automatic send_item(input gb3_pkg::in_item_t it, input bit has_want = 1'b0,
                           input gb3_pkg::out_item_t want = '0);
    gb3_pkg::out_item_t pred;
    if (blur_predict(it, pred)) blurred_fifo.push_back(has_want ? want : pred);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (blurred_fifo.size() != 0);
  endtask

  task automatic apb_xfer(input logic idx, input bit wr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input logic idx);
    logic [31:0] rd, want;
    apb_xfer(idx, 1'b0, '0, rd);
    want = (idx == gb3_pkg::REG_IMAGE_WIDTH) ? 32'(width_reg) : 32'(height_reg);
    if (rd !== want) flag($sformatf("register %0d read %0h, expected %0h", idx, rd, want));
  endtask

  // Frame size changes only once the block has gone quiet.
  task automatic set_size(input logic [31:0] wv, input logic [31:0] hv);
    logic [31:0] unused;
    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    apb_xfer(gb3_pkg::REG_IMAGE_WIDTH, 1'b1, wv, unused);
    width_reg = wv[gb3_pkg::WIDTH_REG_W-1:0];
    apb_xfer(gb3_pkg::REG_IMAGE_HEIGHT, 1'b1, hv, unused);
    height_reg = hv[gb3_pkg::HEIGHT_REG_W-1:0];
    check_reg(gb3_pkg::REG_IMAGE_WIDTH);
    check_reg(gb3_pkg::REG_IMAGE_HEIGHT);
  endtask

  // One frame of random pixels with stray drain ticks, then its drain tail.
  task automatic run_frame(input bit with_pause);
    int unsigned w, h;
    int          pause_at;
    w = eff_w();
    h = eff_h();
    pause_at = with_pause ? int'($urandom_range(w * h - 1)) : -1;
    for (int n = 0; n < w * h; n++) begin
      if (n == pause_at) hold_until_drained();
      if ($urandom_range(24) == 0) send_item(drain_item());
      send_item(rand_pixel());
      useful_items++;
    end
    // Pixels in the tail are discarded, so mix them with drain ticks.
    for (int n = 0; n <= w; n++) begin
      send_item(($urandom_range(2) == 0) ? rand_pixel() : drain_item());
      useful_items++;
    end
    if ($urandom_range(4) == 0) send_item(drain_item());
  endtask

  // Result checking and the no-progress watchdog.
  always @(posedge clk) begin
    gb3_pkg::out_item_t want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (in_valid && !in_stall) items_taken++;
      if (out_valid && !out_stall) begin
        results_seen++;
        if (blurred_fifo.size() == 0) begin
          flag($sformatf("result %s with nothing pending", item_str(out_data)));
        end else begin
          want = blurred_fifo.pop_front();
          if (want.frame_end) frames_done++;
          if (out_data.blue_out !== want.blue_out || out_data.green_out !== want.green_out ||
              out_data.red_out !== want.red_out || out_data.frame_end !== want.frame_end) begin
            flag($sformatf("result %0d: expected %s, got %s", results_seen,
                           item_str(want), item_str(out_data)));
          end
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("gaussian_blur_3x3_stream_tb failed");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] wv, hv;
    int          phase_start;
    bit          first;

    foreach (upper_row[i]) begin
      upper_row[i] = '0;
      middle_row[i] = '0;
    end
    foreach (win[i]) win[i] = '0;
    col_in = 0;
    row_in = 0;
    col_out = 0;
    row_out = 0;

    // A 3x3 frame: only the center pixel is blurred, the rest pass through.
    dir_rows[0]  = '{drain_item(), 1'b0, '0};
    dir_rows[1]  = '{px_item(8'h00, 8'h00, 8'h00), 1'b0, '0};
    dir_rows[2]  = '{px_item(8'hFF, 8'hFF, 8'hFF), 1'b0, '0};
    dir_rows[3]  = '{px_item(8'h80, 8'h7F, 8'h01), 1'b0, '0};
    dir_rows[4]  = '{drain_item(), 1'b0, '0};
    dir_rows[5]  = '{px_item(8'hFF, 8'h00, 8'hFF), 1'b0, '0};
    dir_rows[6]  = '{px_item(8'h00, 8'hFF, 8'h00), 1'b1, px_result(8'h00, 8'h00, 8'h00, 1'b0)};
    dir_rows[7]  = '{px_item(8'h55, 8'hAA, 8'h0F), 1'b1, px_result(8'hFF, 8'hFF, 8'hFF, 1'b0)};
    dir_rows[8]  = '{px_item(8'hFF, 8'hFF, 8'hFF), 1'b1, px_result(8'h80, 8'h7F, 8'h01, 1'b0)};
    dir_rows[9]  = '{px_item(8'h01, 8'h02, 8'h03), 1'b1, px_result(8'hFF, 8'h00, 8'hFF, 1'b0)};
    dir_rows[10] = '{px_item(8'hFE, 8'hFE, 8'hFE), 1'b0, '0};
    // Pixel data arriving after the last row is thrown away.
    dir_rows[11] = '{px_item(8'h12, 8'h34, 8'h56), 1'b1, px_result(8'h55, 8'hAA, 8'h0F, 1'b0)};
    dir_rows[12] = '{drain_item(), 1'b1, px_result(8'hFF, 8'hFF, 8'hFF, 1'b0)};
    dir_rows[13] = '{drain_item(), 1'b1, px_result(8'h01, 8'h02, 8'h03, 1'b0)};
    dir_rows[14] = '{drain_item(), 1'b1, px_result(8'hFE, 8'hFE, 8'hFE, 1'b1)};
    dir_rows[15] = '{drain_item(), 1'b0, '0};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values first, then sizes below the minimum.
    check_reg(gb3_pkg::REG_IMAGE_WIDTH);
    check_reg(gb3_pkg::REG_IMAGE_HEIGHT);
    set_size(32'd0, 32'd0);
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].has_want, dir_rows[i].want);

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = PH_SEND[ph];
      stall_pct = PH_STALL[ph];
      phase_start = useful_items;
      first = 1'b1;
      while (useful_items - phase_start < PHASE_ITEMS) begin
        case ($urandom_range(19))
          0, 1: wv = $urandom_range(2);
          2: wv = $urandom_range(64, 13);
          default: wv = $urandom_range(12, 3);
        endcase
        hv = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(8, 3);
        set_size(wv, hv);
        run_frame(first || $urandom_range(3) == 0);
        first = 1'b0;
      end
      // Full-scale register values are written and read back; no frame runs at that size.
      if (ph == 0) begin
        set_size(32'hFFF, 32'h1FFF);
      end
    end

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d items in and %0d results over %0d frames,", items_taken,
             results_seen, frames_done);
    $display("frames from 3x3 up to 64x8 with clamped sizes, under four flow-control mixes.");
    if (mismatches == 0) begin
      $display("gaussian_blur_3x3_stream_tb passed");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("gaussian_blur_3x3_stream_tb failed");
    end
    $finish;
  end

endmodule
